>>> rtl/core/csnp_pkg.sv
// Shared constants, types and helper functions of the color sort decision block.
// Used by csnp_dist and color_sort_nearest_profile_gate; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package csnp_pkg;

   // Profile table geometry
   localparam int SLOT_COUNT  = 7;
   localparam int SAMPLE_BITS = 12;
   localparam int IDX_W       = $clog2(SLOT_COUNT);
   localparam int SLOT_W      = $clog2(SLOT_COUNT + 1);
   localparam int NO_SLOT     = (1 << SLOT_W) - 1;
   localparam int EMPTY_SLOT  = SLOT_COUNT - 1;

   // Field widths
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int ANGLE_W  = 8;
   localparam int THR_W    = 12;
   localparam int THR2_W   = 2 * THR_W;
   localparam int TICK_W   = 16;
   localparam int LEVEL_W  = 16;
   localparam int SERVO_W  = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Distance arithmetic
   localparam int SQ_W    = 2 * SAMPLE_BITS;
   localparam int DIST_W  = SQ_W + 2;
   localparam int CMP_W   = (DIST_W > THR2_W) ? DIST_W : THR2_W;
   localparam int ENTRY_W = 3 * SAMPLE_BITS + ANGLE_W;

   // Stream packing: request data holds slot, red, green, blue, gate angle
   localparam int REQ_SLOT_LO  = 0;
   localparam int REQ_RED_LO   = REQ_SLOT_LO + SLOT_W;
   localparam int REQ_GREEN_LO = REQ_RED_LO + SAMPLE_BITS;
   localparam int REQ_BLUE_LO  = REQ_GREEN_LO + SAMPLE_BITS;
   localparam int REQ_ANGLE_LO = REQ_BLUE_LO + SAMPLE_BITS;
   localparam int REQ_FIELDS_W = REQ_ANGLE_LO + ANGLE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;

   // Response data holds match slot, servo level, red, green, blue level, locked
   localparam int RSP_FIELDS_W = SLOT_W + SERVO_W + 3 * LEVEL_W + 1;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Request kinds
   localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TRAIN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

   // Scan status codes
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_VALID   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRT_THR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCK      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK     = 2'd3;

   // Register reset values
   localparam int MATCH_RESET = 310;
   localparam int DIRT_RESET  = 223;
   localparam int LOCK_RESET  = 2800;
   localparam int BLINK_RESET = 120;

   // Servo geometry
   localparam int ANGLE_MAX  = 180;
   localparam int ANGLE_HOME = 90;
   localparam int SERVO_MIN  = 1172;
   // ceil(2^16 * 3515 / 180): floor(a * 3515 / 180) is exact for any 8 bit angle
   localparam int SERVO_MUL   = 1279773;
   localparam int SERVO_SHIFT = 16;
   localparam int SERVO_PW    = ANGLE_W + 21;

   // Display levels p*p*65535/10000 for the percentages in use
   localparam logic [LEVEL_W-1:0] LVL_100 = 16'd65535;
   localparam logic [LEVEL_W-1:0] LVL_60  = 16'd23592;
   localparam logic [LEVEL_W-1:0] LVL_30  = 16'd5898;
   localparam logic [LEVEL_W-1:0] LVL_15  = 16'd1474;
   localparam logic [LEVEL_W-1:0] LVL_0   = 16'd0;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } rgb_type;

   // Table read issued to the distance pipeline
   typedef struct packed {
      logic             vld;
      logic [IDX_W-1:0] slot;
   } issue_type;

   // Distance of one stored profile to the current sample
   typedef struct packed {
      logic               vld;
      logic [IDX_W-1:0]   slot;
      logic [DIST_W-1:0]  sq_dist;
      logic [ANGLE_W-1:0] angle;
   } dist_type;

   // Fixed display color of a matched slot
   function automatic rgb_type color_levels(input logic [SLOT_W-1:0] slot);
      rgb_type c;
      c = '{red: LVL_0, green: LVL_0, blue: LVL_0};
      case (slot)
         SLOT_W'(0): c = '{red: LVL_100, green: LVL_0,   blue: LVL_0};
         SLOT_W'(1): c = '{red: LVL_0,   green: LVL_100, blue: LVL_0};
         SLOT_W'(2): c = '{red: LVL_0,   green: LVL_0,   blue: LVL_100};
         SLOT_W'(3): c = '{red: LVL_60,  green: LVL_100, blue: LVL_0};
         SLOT_W'(4): c = '{red: LVL_100, green: LVL_30,  blue: LVL_0};
         SLOT_W'(5): c = '{red: LVL_100, green: LVL_0,   blue: LVL_60};
         default:    c = '{red: LVL_0,   green: LVL_0,   blue: LVL_0};
      endcase
      return c;
   endfunction

   // Servo compare level: SERVO_MIN + floor(angle * 3515 / 180)
   function automatic logic [SERVO_W-1:0] servo_level(input logic [ANGLE_W-1:0] angle);
      logic [SERVO_PW-1:0] prod;
      prod = SERVO_PW'(angle) * SERVO_PW'(SERVO_MUL);
      return SERVO_W'(SERVO_MIN) + SERVO_W'(prod >> SERVO_SHIFT);
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/csnp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read data.
// Stand-alone; holds the color profiles of the decision block.
`timescale 1ns / 1ps
`default_nettype none

module csnp_ram #(
   parameter int WIDTH = 44,
   parameter int DEPTH = 7,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one entry into the registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/csnp_dist.sv
// Squared distance pipeline: aligns a table read with its data, squares the
// per-channel differences, then sums them. Depends on csnp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csnp_dist
   import csnp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire issue_type              issue,
   input  wire logic [ENTRY_W-1:0]     rd_data,
   input  wire logic [SAMPLE_BITS-1:0] sample_red,
   input  wire logic [SAMPLE_BITS-1:0] sample_green,
   input  wire logic [SAMPLE_BITS-1:0] sample_blue,
   output dist_type                    result
);

   logic             algn_vld_ff;
   logic [IDX_W-1:0] algn_slot_ff;

   logic [SAMPLE_BITS-1:0] p_red, p_green, p_blue;
   logic [ANGLE_W-1:0]     p_angle;
   logic [SAMPLE_BITS-1:0] d_red, d_green, d_blue;
   logic [SQ_W-1:0]        sq_red_in, sq_green_in, sq_blue_in;

   logic                   sq_vld_ff;
   logic [IDX_W-1:0]       sq_slot_ff;
   logic [ANGLE_W-1:0]     sq_angle_ff;
   logic [SQ_W-1:0]        sq_red_ff, sq_green_ff, sq_blue_ff;

   logic [DIST_W-1:0]      sum_in;
   dist_type               out_ff;

   // Unpack the stored profile
   assign p_red   = rd_data[SAMPLE_BITS-1:0];
   assign p_green = rd_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign p_blue  = rd_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
   assign p_angle = rd_data[ENTRY_W-1:3*SAMPLE_BITS];

   // Absolute differences and their squares, one lane per channel
   assign d_red   = (sample_red > p_red) ? sample_red - p_red : p_red - sample_red;
   assign d_green = (sample_green > p_green) ? sample_green - p_green
                                             : p_green - sample_green;
   assign d_blue  = (sample_blue > p_blue) ? sample_blue - p_blue : p_blue - sample_blue;

   assign sq_red_in   = SQ_W'(d_red) * SQ_W'(d_red);
   assign sq_green_in = SQ_W'(d_green) * SQ_W'(d_green);
   assign sq_blue_in  = SQ_W'(d_blue) * SQ_W'(d_blue);

   assign sum_in = DIST_W'(sq_red_ff) + DIST_W'(sq_green_ff) + DIST_W'(sq_blue_ff);

   // Track which slot the read data belongs to
   always_ff @(posedge clock) begin
      if (reset) begin
         algn_vld_ff <= 1'b0;
      end else begin
         algn_vld_ff <= issue.vld;
      end
      algn_slot_ff <= issue.slot;
   end

   // Square stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
      end else begin
         sq_vld_ff <= algn_vld_ff;
      end
      sq_slot_ff  <= algn_slot_ff;
      sq_angle_ff <= p_angle;
      sq_red_ff   <= sq_red_in;
      sq_green_ff <= sq_green_in;
      sq_blue_ff  <= sq_blue_in;
   end

   // Sum stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else begin
         out_ff.vld <= sq_vld_ff;
      end
      out_ff.slot    <= sq_slot_ff;
      out_ff.sq_dist <= sum_in;
      out_ff.angle   <= sq_angle_ff;
   end

   assign result = out_ff;

endmodule

`default_nettype wire

>>> rtl/core/color_sort_nearest_profile_gate.sv
// Top level of the color sort decision block: request sequencer, profile valid
// bits, servo and display state. Depends on csnp_pkg, csnp_ram and csnp_dist.
`timescale 1ns / 1ps
`default_nettype none

// Nearest-profile color classifier with an empty-belt gate. Train requests
// store a slot's red, green and blue codes and a gate angle (clamped to 180)
// in a small profile RAM; tick requests count down the servo lock and the idle
// blink timer. Neither gives a response. A scan request walks the profile RAM
// one slot per cycle through a three-stage distance pipeline and then decides;
// the input is busy until the decision is taken. A scan with no trained slot
// skips the walk and goes straight to the decision. Each scan gives exactly one
// response carrying status, matched slot, servo level, display levels and the
// lock flag; a response waiting in the output register does not block the
// next request, only the next scan's decision. Configuration writes are taken
// on every cycle.
module color_sort_nearest_profile_gate
   import csnp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // from bit 0: slot, red_code, green_code, blue_code, gate_angle
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // from bit 0: kind
   input  wire logic [KIND_W-1:0]     req_tuser,
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // from bit 0: match_slot, servo_level, red_level, green_level, blue_level, locked
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // from bit 0: status
   output logic [STATUS_W-1:0]        rsp_tuser,
   // configuration writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   localparam rgb_type BLINK_RGB = '{red: LVL_15, green: LVL_15, blue: LVL_15};
   localparam rgb_type DARK_RGB  = '{red: LVL_0, green: LVL_0, blue: LVL_0};

   // Request fields
   logic [SLOT_W-1:0]      f_slot;
   logic [SAMPLE_BITS-1:0] f_red, f_green, f_blue;
   logic [ANGLE_W-1:0]     f_angle, f_angle_clamped;
   logic                   req_fire;

   // Sequencer
   logic [1:0]             state_ff, state_in;
   logic                   issue_on_ff, issue_on_in;
   logic [IDX_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                   any_ff, any_in;

   // Scan sample
   logic [SAMPLE_BITS-1:0] smp_red_ff, smp_green_ff, smp_blue_ff;

   // Nearest-slot search
   logic                   found_ff, found_in;
   logic [DIST_W-1:0]      bestd_ff, bestd_in;
   logic [SLOT_W-1:0]      best_slot_ff, best_slot_in;
   logic [ANGLE_W-1:0]     best_angle_ff, best_angle_in;
   logic                   dirty_ff, dirty_in;
   logic [ANGLE_W-1:0]     empty_angle_ff, empty_angle_in;

   // Persistent block state
   logic [SLOT_COUNT-1:0]  valid_ff, valid_in;
   logic                   servo_hold_ff, servo_hold_in;
   logic [TICK_W-1:0]      hold_cnt_ff, hold_cnt_in;
   logic [ANGLE_W-1:0]     angle_ff, angle_in;
   logic                   blink_phase_ff, blink_phase_in;
   logic [TICK_W-1:0]      blink_cnt_ff, blink_cnt_in;
   rgb_type                disp_ff, disp_in;

   // Configuration
   logic [THR2_W-1:0]      mt2_ff, dt2_ff;
   logic [TICK_W-1:0]      lock_ticks_ff, blink_ticks_ff;
   logic                   csr_fire;

   // Response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [SERVO_W-1:0]     rsp_servo_ff, rsp_servo_in;
   rgb_type                rsp_disp_ff, rsp_disp_in;
   logic                   rsp_locked_ff, rsp_locked_in;
   logic                   out_free;

   // Decision helpers
   logic                   hold_kept;
   logic                   blink_phase_nx;
   logic [TICK_W-1:0]      blink_cnt_nx;
   logic                   is_match;
   logic                   empty_hit;

   // RAM and distance pipeline
   logic                   ram_wr;
   logic [ENTRY_W-1:0]     ram_wr_data;
   logic [ENTRY_W-1:0]     ram_rd_data;
   issue_type              issue;
   dist_type               dist_res;
   logic                   dist_on;
   logic                   dist_last;

   // Unpack request fields
   assign f_slot  = req_tdata[REQ_SLOT_LO +: SLOT_W];
   assign f_red   = req_tdata[REQ_RED_LO +: SAMPLE_BITS];
   assign f_green = req_tdata[REQ_GREEN_LO +: SAMPLE_BITS];
   assign f_blue  = req_tdata[REQ_BLUE_LO +: SAMPLE_BITS];
   assign f_angle = req_tdata[REQ_ANGLE_LO +: ANGLE_W];
   assign f_angle_clamped = (f_angle > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : f_angle;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;
   assign csr_fire    = csr_valid && csr_ready;
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign ram_wr_data = {f_angle_clamped, f_blue, f_green, f_red};

   assign issue.vld  = issue_on_ff;
   assign issue.slot = issue_idx_ff;

   csnp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (IDX_W'(f_slot)),
      .wr_data (ram_wr_data),
      .rd_en   (issue_on_ff),
      .rd_addr (issue_idx_ff),
      .rd_data (ram_rd_data)
   );

   csnp_dist u_dist (
      .clock        (clock),
      .reset        (reset),
      .issue        (issue),
      .rd_data      (ram_rd_data),
      .sample_red   (smp_red_ff),
      .sample_green (smp_green_ff),
      .sample_blue  (smp_blue_ff),
      .result       (dist_res)
   );

   assign dist_on   = dist_res.vld && valid_ff[dist_res.slot];
   assign dist_last = dist_res.vld && (dist_res.slot == IDX_W'(SLOT_COUNT - 1));

   // Decision terms: lock release, blink step, threshold and empty-belt tests
   assign hold_kept      = servo_hold_ff && (hold_cnt_ff != '0);
   assign blink_phase_nx = (blink_cnt_ff == '0) ? !blink_phase_ff : blink_phase_ff;
   assign blink_cnt_nx   = (blink_cnt_ff == '0) ? blink_ticks_ff : blink_cnt_ff;
   assign is_match       = CMP_W'(bestd_ff) <= CMP_W'(mt2_ff);
   assign empty_hit      = (best_slot_ff == SLOT_W'(EMPTY_SLOT)) || dirty_ff;

   // Next-state logic
   always_comb begin
      state_in       = state_ff;
      issue_on_in    = issue_on_ff;
      issue_idx_in   = issue_idx_ff;
      any_in         = any_ff;
      found_in       = found_ff;
      bestd_in       = bestd_ff;
      best_slot_in   = best_slot_ff;
      best_angle_in  = best_angle_ff;
      dirty_in       = dirty_ff;
      empty_angle_in = empty_angle_ff;
      valid_in       = valid_ff;
      servo_hold_in  = servo_hold_ff;
      hold_cnt_in    = hold_cnt_ff;
      angle_in       = angle_ff;
      blink_phase_in = blink_phase_ff;
      blink_cnt_in   = blink_cnt_ff;
      disp_in        = disp_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_servo_in   = rsp_servo_ff;
      rsp_disp_in    = rsp_disp_ff;
      rsp_locked_in  = rsp_locked_ff;
      ram_wr         = 1'b0;

      // Fold each distance into the running minimum; first slot wins ties
      if (dist_on) begin
         if (!found_ff || (dist_res.sq_dist < bestd_ff)) begin
            found_in      = 1'b1;
            bestd_in      = dist_res.sq_dist;
            best_slot_in  = SLOT_W'(dist_res.slot);
            best_angle_in = dist_res.angle;
         end
         if (dist_res.slot == IDX_W'(EMPTY_SLOT)) begin
            dirty_in       = CMP_W'(dist_res.sq_dist) < CMP_W'(dt2_ff);
            empty_angle_in = dist_res.angle;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  KIND_SCAN: begin
                     found_in     = 1'b0;
                     dirty_in     = 1'b0;
                     best_slot_in = SLOT_W'(NO_SLOT);
                     any_in       = |valid_ff;
                     if (|valid_ff) begin
                        issue_on_in  = 1'b1;
                        issue_idx_in = '0;
                        state_in     = ST_WALK;
                     end else begin
                        state_in = ST_DECIDE;
                     end
                  end
                  KIND_TRAIN: begin
                     if (f_slot < SLOT_W'(SLOT_COUNT)) begin
                        ram_wr                  = 1'b1;
                        valid_in[IDX_W'(f_slot)] = 1'b1;
                     end
                  end
                  KIND_TICK: begin
                     if (hold_cnt_ff != '0) begin
                        hold_cnt_in = hold_cnt_ff - TICK_W'(1);
                     end
                     if (blink_cnt_ff != '0) begin
                        blink_cnt_in = blink_cnt_ff - TICK_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_WALK: begin
            // Issue one table read per cycle, then wait for the last distance
            if (issue_on_ff) begin
               if (issue_idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_idx_in = issue_idx_ff + IDX_W'(1);
               end
            end
            if (dist_last) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            // Hold the decision until the response register is free
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = best_slot_ff;
               if (!any_ff) begin
                  rsp_status_in = STATUS_NONE;
               end else if (is_match && empty_hit) begin
                  rsp_status_in = STATUS_EMPTY;
                  servo_hold_in = hold_kept;
                  if (!hold_kept) begin
                     angle_in = valid_ff[EMPTY_SLOT] ? empty_angle_ff : ANGLE_W'(ANGLE_HOME);
                     blink_phase_in = blink_phase_nx;
                     blink_cnt_in   = blink_cnt_nx;
                     disp_in        = blink_phase_nx ? BLINK_RGB : DARK_RGB;
                  end
               end else if (is_match) begin
                  rsp_status_in = STATUS_VALID;
                  servo_hold_in = 1'b1;
                  hold_cnt_in   = lock_ticks_ff;
                  angle_in      = best_angle_ff;
                  disp_in       = color_levels(best_slot_ff);
               end else begin
                  rsp_status_in = STATUS_UNKNOWN;
                  servo_hold_in = hold_kept;
                  if (!hold_kept) begin
                     blink_phase_in = blink_phase_nx;
                     blink_cnt_in   = blink_cnt_nx;
                     disp_in        = blink_phase_nx ? BLINK_RGB : DARK_RGB;
                  end
               end
               rsp_servo_in  = servo_level(angle_in);
               rsp_disp_in   = disp_in;
               rsp_locked_in = servo_hold_in;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_on_ff    <= 1'b0;
         valid_ff       <= '0;
         servo_hold_ff  <= 1'b0;
         hold_cnt_ff    <= '0;
         angle_ff       <= ANGLE_W'(ANGLE_HOME);
         blink_phase_ff <= 1'b0;
         blink_cnt_ff   <= '0;
         disp_ff        <= DARK_RGB;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_on_ff    <= issue_on_in;
         valid_ff       <= valid_in;
         servo_hold_ff  <= servo_hold_in;
         hold_cnt_ff    <= hold_cnt_in;
         angle_ff       <= angle_in;
         blink_phase_ff <= blink_phase_in;
         blink_cnt_ff   <= blink_cnt_in;
         disp_ff        <= disp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Scan working registers and response payload
   always_ff @(posedge clock) begin
      issue_idx_ff   <= issue_idx_in;
      any_ff         <= any_in;
      found_ff       <= found_in;
      bestd_ff       <= bestd_in;
      best_slot_ff   <= best_slot_in;
      best_angle_ff  <= best_angle_in;
      dirty_ff       <= dirty_in;
      empty_angle_ff <= empty_angle_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_servo_ff   <= rsp_servo_in;
      rsp_disp_ff    <= rsp_disp_in;
      rsp_locked_ff  <= rsp_locked_in;
      if (req_fire && (req_tuser == KIND_SCAN)) begin
         smp_red_ff   <= f_red;
         smp_green_ff <= f_green;
         smp_blue_ff  <= f_blue;
      end
   end

   // Configuration registers; thresholds are kept squared
   always_ff @(posedge clock) begin
      if (reset) begin
         mt2_ff         <= THR2_W'(MATCH_RESET * MATCH_RESET);
         dt2_ff         <= THR2_W'(DIRT_RESET * DIRT_RESET);
         lock_ticks_ff  <= TICK_W'(LOCK_RESET);
         blink_ticks_ff <= TICK_W'(BLINK_RESET);
      end else if (csr_fire) begin
         case (csr_index)
            CSR_MATCH_THR: mt2_ff <= THR2_W'(csr_data[THR_W-1:0]) * THR2_W'(csr_data[THR_W-1:0]);
            CSR_DIRT_THR:  dt2_ff <= THR2_W'(csr_data[THR_W-1:0]) * THR2_W'(csr_data[THR_W-1:0]);
            CSR_LOCK:      lock_ticks_ff  <= csr_data[TICK_W-1:0];
            CSR_BLINK:     blink_ticks_ff <= csr_data[TICK_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Drive the response stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_locked_ff, rsp_disp_ff.blue, rsp_disp_ff.green,
                                    rsp_disp_ff.red, rsp_servo_ff, rsp_slot_ff});

endmodule

`default_nettype wire

>>> tb/sort_decision_checker.sv
// Checker for the color sort decision block: mirrors the profile table, servo
// lock, idle blink and register state, predicts one decision per scan request
// and compares every response. Depends on csnp_pkg only.
`timescale 1ns / 1ps

module sort_decision_checker
   import csnp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic [STATUS_W-1:0]   rsp_tuser,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    mismatch_count,
   output int                    pending_count
);

   localparam int SERVO_TOP = 4687;
   localparam int BLINK_PCT = 15;

   // Response field offsets, from bit 0 up
   localparam int RSP_SLOT_LO  = 0;
   localparam int RSP_SERVO_LO = RSP_SLOT_LO + SLOT_W;
   localparam int RSP_RED_LO   = RSP_SERVO_LO + SERVO_W;
   localparam int RSP_GREEN_LO = RSP_RED_LO + LEVEL_W;
   localparam int RSP_BLUE_LO  = RSP_GREEN_LO + LEVEL_W;
   localparam int RSP_LOCK_LO  = RSP_BLUE_LO + LEVEL_W;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [SERVO_W-1:0]  servo;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
      logic                locked;
   } decision_type;

   // Mirrored profile table
   logic prof_on    [SLOT_COUNT];
   int   prof_red   [SLOT_COUNT];
   int   prof_green [SLOT_COUNT];
   int   prof_blue  [SLOT_COUNT];
   int   prof_angle [SLOT_COUNT];

   // Servo, blink and display state
   logic hold_on;
   int   hold_left;
   int   angle_now;
   logic blink_on;
   int   blink_left;
   int   lvl_red, lvl_green, lvl_blue;

   // Register copies
   int thr_match, thr_dirt, lock_len, blink_len;

   decision_type expected_decisions[$];
   decision_type want_d;

   function automatic int pct_level(input int p);
      return p * p * 65535 / 10000;
   endfunction

   function automatic longint code_dist(input int slot, input int r, input int g, input int b);
      longint dr, dg, db;
      dr = r - prof_red[slot];
      dg = g - prof_green[slot];
      db = b - prof_blue[slot];
      return dr * dr + dg * dg + db * db;
   endfunction

   task automatic show_pct(input int rp, input int gp, input int bp);
      lvl_red   = pct_level(rp);
      lvl_green = pct_level(gp);
      lvl_blue  = pct_level(bp);
   endtask

   // Fixed display color of a matched slot, in percent
   task automatic show_slot_color(input int slot);
      case (slot)
         0: show_pct(100, 0, 0);
         1: show_pct(0, 100, 0);
         2: show_pct(0, 0, 100);
         3: show_pct(60, 100, 0);
         4: show_pct(100, 30, 0);
         5: show_pct(100, 0, 60);
         default: show_pct(0, 0, 0);
      endcase
   endtask

   // Toggle the dim white blink once its countdown has run out
   task automatic blink_step();
      if (blink_left == 0) begin
         blink_on   = !blink_on;
         blink_left = blink_len;
      end
      if (blink_on) show_pct(BLINK_PCT, BLINK_PCT, BLINK_PCT);
      else show_pct(0, 0, 0);
   endtask

   task automatic clear_state();
      for (int i = 0; i < SLOT_COUNT; i++) begin
         prof_on[i]    = 1'b0;
         prof_red[i]   = 0;
         prof_green[i] = 0;
         prof_blue[i]  = 0;
         prof_angle[i] = 0;
      end
      hold_on    = 1'b0;
      hold_left  = 0;
      angle_now  = ANGLE_HOME;
      blink_on   = 1'b0;
      blink_left = 0;
      show_pct(0, 0, 0);
      thr_match = MATCH_RESET;
      thr_dirt  = DIRT_RESET;
      lock_len  = LOCK_RESET;
      blink_len = BLINK_RESET;
      expected_decisions.delete();
      mismatch_count = 0;
   endtask

   // Update the mirror for one request; a scan queues its decision
   task automatic classify_request(input logic [KIND_W-1:0] kind,
                                   input logic [REQ_DATA_W-1:0] data);
      int           slot, r, g, b, ang, best;
      longint       bestd, d, match2, dirt2;
      logic         any, dirty;
      decision_type res;
      slot = data[REQ_SLOT_LO +: SLOT_W];
      r    = data[REQ_RED_LO +: SAMPLE_BITS];
      g    = data[REQ_GREEN_LO +: SAMPLE_BITS];
      b    = data[REQ_BLUE_LO +: SAMPLE_BITS];
      ang  = data[REQ_ANGLE_LO +: ANGLE_W];
      if (kind == KIND_TICK) begin
         if (hold_left != 0) hold_left--;
         if (blink_left != 0) blink_left--;
      end else if (kind == KIND_TRAIN) begin
         if (slot < SLOT_COUNT) begin
            prof_red[slot]   = r;
            prof_green[slot] = g;
            prof_blue[slot]  = b;
            prof_angle[slot] = (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
            prof_on[slot]    = 1'b1;
         end
      end else if (kind == KIND_SCAN) begin
         any = 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) any |= prof_on[i];
         best  = NO_SLOT;
         bestd = 0;
         if (!any) begin
            res.status = STATUS_NONE;
         end else begin
            match2 = longint'(thr_match) * thr_match;
            dirt2  = longint'(thr_dirt) * thr_dirt;
            if (hold_on && hold_left == 0) hold_on = 1'b0;
            // nearest active slot, lowest index wins ties
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (prof_on[i]) begin
                  d = code_dist(i, r, g, b);
                  if (best == NO_SLOT || d < bestd) begin
                     bestd = d;
                     best  = i;
                  end
               end
            end
            dirty = prof_on[EMPTY_SLOT] && (code_dist(EMPTY_SLOT, r, g, b) < dirt2);
            if (bestd <= match2) begin
               if (best == EMPTY_SLOT || dirty) begin
                  res.status = STATUS_EMPTY;
                  if (!hold_on) begin
                     angle_now = prof_on[EMPTY_SLOT] ? prof_angle[EMPTY_SLOT] : ANGLE_HOME;
                     blink_step();
                  end
               end else begin
                  res.status = STATUS_VALID;
                  hold_left  = lock_len;
                  hold_on    = 1'b1;
                  angle_now  = prof_angle[best];
                  show_slot_color(best);
               end
            end else begin
               res.status = STATUS_UNKNOWN;
               if (!hold_on) blink_step();
            end
         end
         res.slot   = SLOT_W'(best);
         res.servo  = SERVO_W'(SERVO_MIN + angle_now * (SERVO_TOP - SERVO_MIN) / ANGLE_MAX);
         res.red    = LEVEL_W'(lvl_red);
         res.green  = LEVEL_W'(lvl_green);
         res.blue   = LEVEL_W'(lvl_blue);
         res.locked = hold_on;
         expected_decisions.push_back(res);
      end
   endtask

   task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                              input logic [LEVEL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Compare responses first, then take register writes and requests
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_decisions.size() == 0) begin
               $error("response with no scan outstanding: status %0d", rsp_tuser);
               mismatch_count++;
            end else begin
               want_d = expected_decisions.pop_front();
               check_field("status", LEVEL_W'(want_d.status), LEVEL_W'(rsp_tuser));
               check_field("match_slot", LEVEL_W'(want_d.slot),
                           LEVEL_W'(rsp_tdata[RSP_SLOT_LO +: SLOT_W]));
               check_field("servo_level", LEVEL_W'(want_d.servo),
                           LEVEL_W'(rsp_tdata[RSP_SERVO_LO +: SERVO_W]));
               check_field("red_level", want_d.red, rsp_tdata[RSP_RED_LO +: LEVEL_W]);
               check_field("green_level", want_d.green, rsp_tdata[RSP_GREEN_LO +: LEVEL_W]);
               check_field("blue_level", want_d.blue, rsp_tdata[RSP_BLUE_LO +: LEVEL_W]);
               check_field("locked", LEVEL_W'(want_d.locked),
                           LEVEL_W'(rsp_tdata[RSP_LOCK_LO]));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MATCH_THR: thr_match = csr_data[THR_W-1:0];
               CSR_DIRT_THR:  thr_dirt  = csr_data[THR_W-1:0];
               CSR_LOCK:      lock_len  = csr_data[TICK_W-1:0];
               CSR_BLINK:     blink_len = csr_data[TICK_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) classify_request(req_tuser, req_tdata);
      end
      pending_count = expected_decisions.size();
   end

endmodule

>>> tb/tb.sv
// Testbench top for color_sort_nearest_profile_gate: clock, reset, request,
// register and response stimulus, watchdog and verdict. Checking is done by
// sort_decision_checker; depends on csnp_pkg and the block itself.
`timescale 1ns / 1ps

module tb;
   import csnp_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_ITEMS  = 385;
   localparam int PRESS_CYCLES = 400;
   localparam int CODE_MAX     = (1 << SAMPLE_BITS) - 1;
   localparam int TICK_MAX     = (1 << TICK_W) - 1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [KIND_W-1:0]     req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int                    mismatch_count;
   int                    pending_count;

   logic calm;
   logic press_rsp;
   int   items_sent;
   int   stall_cycles;
   int   known_red   [SLOT_COUNT];
   int   known_green [SLOT_COUNT];
   int   known_blue  [SLOT_COUNT];

   color_sort_nearest_profile_gate dut (.*);
   sort_decision_checker checker_i (.*);

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic logic [REQ_DATA_W-1:0] pack_req(input int slot, input int r, input int g,
                                                      input int b, input int ang);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      d[REQ_SLOT_LO +: SLOT_W]       = SLOT_W'(slot);
      d[REQ_RED_LO +: SAMPLE_BITS]   = SAMPLE_BITS'(r);
      d[REQ_GREEN_LO +: SAMPLE_BITS] = SAMPLE_BITS'(g);
      d[REQ_BLUE_LO +: SAMPLE_BITS]  = SAMPLE_BITS'(b);
      d[REQ_ANGLE_LO +: ANGLE_W]     = ANGLE_W'(ang);
      return d;
   endfunction

   function automatic logic [REQ_DATA_W-1:0] noise_req();
      return pack_req($urandom_range(0, 7), $urandom_range(0, CODE_MAX),
                      $urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
                      $urandom_range(0, 255));
   endfunction

   // Code near a trained value, clamped to the ADC range
   function automatic int jitter(input int code, input int spread);
      int v;
      v = code + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > CODE_MAX) v = CODE_MAX;
      return v;
   endfunction

   // Offer one request, with random idle cycles ahead of it; returns at a falling edge
   task automatic send_req(input logic [KIND_W-1:0] kind, input logic [REQ_DATA_W-1:0] data);
      while (!calm && $urandom_range(0, 99) < 9) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      if (kind != KIND_UNUSED) items_sent++;
   endtask

   task automatic train_slot(input int slot, input int r, input int g, input int b,
                             input int ang);
      if (slot < SLOT_COUNT) begin
         known_red[slot]   = r;
         known_green[slot] = g;
         known_blue[slot]  = b;
      end
      send_req(KIND_TRAIN, pack_req(slot, r, g, b, ang));
   endtask

   task automatic scan_codes(input int r, input int g, input int b);
      send_req(KIND_SCAN, pack_req($urandom_range(0, 7), r, g, b, $urandom_range(0, 255)));
   endtask

   // Drop valid, wait for all decisions and let the block go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_config(input int match_thr, input int dirt_thr, input int lock_len,
                             input int blink_len);
      settle();
      write_csr(CSR_MATCH_THR, match_thr);
      write_csr(CSR_DIRT_THR, dirt_thr);
      write_csr(CSR_LOCK, lock_len);
      write_csr(CSR_BLINK, blink_len);
      csr_valid <= 1'b0;
   endtask

   // One random step: mostly scans near trained profiles and tick bursts
   task automatic random_item();
      int pick, s, spread, n;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if ($urandom_range(0, 99) < 85) begin
            s = $urandom_range(0, SLOT_COUNT - 1);
            n = $urandom_range(0, 99);
            spread = (n < 10) ? 0 : (n < 60) ? 60 : (n < 90) ? 400 : 1500;
            scan_codes(jitter(known_red[s], spread), jitter(known_green[s], spread),
                       jitter(known_blue[s], spread));
         end else begin
            scan_codes($urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
                       $urandom_range(0, CODE_MAX));
         end
      end else if (pick < 85) begin
         n = $urandom_range(1, 8);
         repeat (n) send_req(KIND_TICK, noise_req());
      end else if (pick < 97) begin
         train_slot($urandom_range(0, 7), $urandom_range(0, CODE_MAX),
                    $urandom_range(0, CODE_MAX), $urandom_range(0, CODE_MAX),
                    $urandom_range(0, 255));
      end else begin
         send_req(KIND_UNUSED, noise_req());
      end
   endtask

   // Response side: random stalls, one long hold-off on request, calm stretch
   initial begin : rsp_side
      int   hold_left;
      logic press_done;
      hold_left  = 0;
      press_done = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (press_rsp && !press_done) begin
            press_done = 1'b1;
            hold_left  = PRESS_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (calm) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 9);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int start;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = KIND_SCAN;
      csr_valid  = 1'b0;
      csr_index  = CSR_MATCH_THR;
      csr_data   = '0;
      calm       = 1'b0;
      press_rsp  = 1'b0;
      items_sent = 0;
      stall_cycles = 0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         known_red[i]   = 0;
         known_green[i] = 0;
         known_blue[i]  = 0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Short lock, blink toggling on every idle scan
      set_config(MATCH_RESET, DIRT_RESET, 2, 0);

      // No profiles yet: scans report nothing, unused kind and bad slot are dropped
      scan_codes(0, 0, 0);
      send_req(KIND_TICK, noise_req());
      send_req(KIND_UNUSED, noise_req());
      train_slot(7, CODE_MAX, CODE_MAX, CODE_MAX, 255);
      scan_codes(CODE_MAX, CODE_MAX, CODE_MAX);

      // Code extremes, angle clamp, lock held then released
      train_slot(0, 0, 0, 0, 255);
      train_slot(1, CODE_MAX, CODE_MAX, CODE_MAX, 0);
      scan_codes(0, 0, 0);
      scan_codes(CODE_MAX, CODE_MAX, CODE_MAX);
      scan_codes(2048, 2048, 2048);
      repeat (3) send_req(KIND_TICK, noise_req());
      scan_codes(2048, 2048, 2048);
      scan_codes(2048, 2048, 2048);

      // Equal distances to two slots: lower slot wins
      train_slot(2, 100, 100, 100, 180);
      train_slot(3, 300, 100, 100, 30);
      scan_codes(200, 100, 100);
      repeat (3) send_req(KIND_TICK, noise_req());

      // Empty belt profile, dirt gate, then a plain valid item
      train_slot(6, 1000, 1000, 1000, 45);
      scan_codes(1000, 1000, 1000);
      train_slot(4, 1100, 1000, 1000, 120);
      scan_codes(1090, 1000, 1000);
      train_slot(5, 3000, 500, 200, 60);
      scan_codes(3010, 495, 200);

      // Random phases under different register settings
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_config(MATCH_RESET, DIRT_RESET, 5, 3);
            1: set_config(CODE_MAX, 0, 0, 1);
            2: set_config(0, CODE_MAX, TICK_MAX, TICK_MAX);
            3: set_config(600, 300, 20, 2);
            default: set_config($urandom_range(100, 1000), $urandom_range(0, 600),
                                $urandom_range(0, 15), $urandom_range(0, 8));
         endcase
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) begin
            if (ph == 1 && items_sent - start >= 100) press_rsp = 1'b1;
            calm = (ph == 3) && (items_sent - start >= 50) && (items_sent - start < 250);
            random_item();
         end
         calm = 1'b0;
      end

      settle();
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
